### sv/kmds_pkg.sv
`default_nettype none

package kmds_pkg;

  // Default matrix geometry.
  localparam int ROWS_DEFAULT = 6;
  localparam int COLS_DEFAULT = 17;

  // Field widths of the item and result channels.
  localparam int COLUMN_W  = 5;
  localparam int SENSE_W   = 6;
  localparam int STABLE_W  = 6;
  localparam int PRESSED_W = 7;
  localparam int SCANS_W   = 8;

  // Debounce setting after reset, also the counter's reset value.
  localparam logic [SCANS_W-1:0] SCANS_RESET = 8'd5;

  // Largest value the pressed-key count field can carry.
  localparam logic [PRESSED_W-1:0] PRESSED_MAX = 7'd127;

  // What one row lane reports to the merging stage for the current item.
  typedef struct packed {
    logic diff;        // sensed bit differs from the raw store (gated by update)
    logic cur;         // sensed bit for this row
    logic prev;        // raw store bit before this item
    logic stable_bit;  // stable store bit before this item
  } lane_status_t;

endpackage

`default_nettype wire

### sv/kmds_lane.sv
`default_nettype none

module kmds_lane #(
  parameter int COLS = kmds_pkg::COLS_DEFAULT,
  localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       en,
  input  wire  [CIW-1:0]            col_idx,
  input  wire                       sense_bit,
  input  wire                       commit,
  output kmds_pkg::lane_status_t    status
);

  // One row of the raw and stable key stores, bit c is column c.
  logic [COLS-1:0] raw_row;
  logic [COLS-1:0] stable_row;
  logic [COLS-1:0] raw_row_next;
  logic            raw_bit;

  // Compare the sensed bit with the stored raw bit of the strobed column.
  always_comb begin
    raw_bit      = raw_row[col_idx];
    raw_row_next = raw_row;
    if (en) begin
      raw_row_next[col_idx] = sense_bit;
    end
    status.diff       = en & (raw_bit != sense_bit);
    status.cur        = sense_bit;
    status.prev       = raw_bit;
    status.stable_bit = stable_row[col_idx];
  end

  // Raw store follows every in-range item; the stable store takes the raw row on commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_row    <= '0;
      stable_row <= '0;
    end else begin
      raw_row <= raw_row_next;
      if (commit) begin
        stable_row <= raw_row_next;
      end
    end
  end

endmodule

`default_nettype wire

### sv/kmds_merge.sv
`default_nettype none

module kmds_merge #(
  parameter int ROWS = kmds_pkg::ROWS_DEFAULT,
  parameter int COLS = kmds_pkg::COLS_DEFAULT,
  localparam int CNT_W = $clog2(ROWS * COLS + 1)
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   fire,
  input  wire                                   in_range,
  input  wire                                   is_last,
  input  kmds_pkg::lane_status_t [ROWS-1:0]     lane_st,
  input  wire                                   cfg_we,
  input  wire  [kmds_pkg::SCANS_W-1:0]          cfg_wdata,
  input  wire                                   result_stall,
  output logic                                  commit,
  output logic                                  item_stall,
  output logic                                  result_valid,
  output logic [kmds_pkg::STABLE_W-1:0]         stable_column_bits,
  output logic                                  committed,
  output logic                                  settled,
  output logic [kmds_pkg::PRESSED_W-1:0]        pressed_count
);

  logic [kmds_pkg::SCANS_W-1:0]   debounce_scans;
  logic [kmds_pkg::SCANS_W-1:0]   debounce_count;
  logic [kmds_pkg::SCANS_W-1:0]   debounce_count_next;
  logic [kmds_pkg::SCANS_W-1:0]   count_mid;
  logic [CNT_W-1:0]               raw_count;
  logic [CNT_W-1:0]               raw_count_next;
  logic [CNT_W-1:0]               stable_count;
  logic [CNT_W-1:0]               stable_count_next;
  logic [CNT_W-1:0]               cur_ones;
  logic [CNT_W-1:0]               prev_ones;
  logic [kmds_pkg::STABLE_W-1:0]  col_bits;
  logic [kmds_pkg::PRESSED_W-1:0] pressed_sat;
  logic                           any_diff;
  logic                           update;
  logic                           dec;

  // A full output register holds off new items only while it is stalled.
  assign item_stall = result_valid & result_stall;
  assign update     = fire & in_range;

  // Merge what the lanes found: any change, and ones counts for the raw tally.
  always_comb begin
    any_diff  = 1'b0;
    cur_ones  = '0;
    prev_ones = '0;
    for (int r = 0; r < ROWS; r++) begin
      any_diff  = any_diff | lane_st[r].diff;
      cur_ones  = cur_ones + CNT_W'(lane_st[r].cur);
      prev_ones = prev_ones + CNT_W'(lane_st[r].prev);
    end
  end

  // Shared debounce counter: reload on change, count down after the last column.
  always_comb begin
    count_mid           = any_diff ? debounce_scans : debounce_count;
    dec                 = update & is_last & (count_mid != '0);
    debounce_count_next = dec ? count_mid - 1'b1 : count_mid;
    commit              = dec & (count_mid == kmds_pkg::SCANS_W'(1));
  end

  // Key tallies: the raw count tracks each item, the stable count copies it on commit.
  always_comb begin
    raw_count_next    = update ? raw_count + cur_ones - prev_ones : raw_count;
    stable_count_next = commit ? raw_count_next : stable_count;
    if (stable_count_next > CNT_W'(kmds_pkg::PRESSED_MAX)) begin
      pressed_sat = kmds_pkg::PRESSED_MAX;
    end else begin
      pressed_sat = kmds_pkg::PRESSED_W'(stable_count_next);
    end
  end

  // Stable bits of the strobed column after this item, rows that fit the field.
  always_comb begin
    col_bits = '0;
    for (int b = 0; b < kmds_pkg::STABLE_W; b++) begin
      if (b < ROWS) begin
        col_bits[b] = in_range & (commit ? lane_st[b].cur : lane_st[b].stable_bit);
      end
    end
  end

  // Control state and configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_scans <= kmds_pkg::SCANS_RESET;
      debounce_count <= kmds_pkg::SCANS_RESET;
      raw_count      <= '0;
      stable_count   <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        debounce_scans <= cfg_wdata;
      end
      if (fire) begin
        debounce_count <= debounce_count_next;
      end
      raw_count    <= raw_count_next;
      stable_count <= stable_count_next;
      result_valid <= fire | (result_valid & result_stall);
    end
  end

  // Output register for the result item.
  always_ff @(posedge clk) begin
    if (fire) begin
      stable_column_bits <= col_bits;
      committed          <= commit;
      settled            <= (debounce_count_next == '0);
      pressed_count      <= pressed_sat;
    end
  end

endmodule

`default_nettype wire

### sv/key_matrix_debounce_scanner.sv
// Key matrix scanner with one shared debounce counter. Each item carries the
// row-sense bits of one strobed column (sense bit ROWS-1-r is row r) and yields
// one result: the debounced key bits of that column, a commit flag, a settled
// flag and the number of pressed keys in the debounced store. One row lane per
// matrix row compares and updates its row of the raw store in parallel, so an
// item is accepted every clock cycle and its result appears in the next cycle
// in the output register; the block stops taking items only while that register
// is full and stalled. After the item for the last column the counter counts
// down, and when it reaches zero the raw store becomes the debounced store.
// The debounce setting is written through cfg_we/cfg_wdata while idle and must
// be at least 1. Items with a column index of COLS or more change nothing and
// report zero key bits.
`default_nettype none

module key_matrix_debounce_scanner #(
  parameter int ROWS = kmds_pkg::ROWS_DEFAULT,
  parameter int COLS = kmds_pkg::COLS_DEFAULT
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 item_valid,
  output logic                                item_stall,
  input  wire  [kmds_pkg::COLUMN_W-1:0]       column,
  input  wire  [kmds_pkg::SENSE_W-1:0]        row_sense,
  input  wire                                 cfg_we,
  input  wire  [kmds_pkg::SCANS_W-1:0]        cfg_wdata,
  output logic                                result_valid,
  input  wire                                 result_stall,
  output logic [kmds_pkg::STABLE_W-1:0]       stable_column_bits,
  output logic                                committed,
  output logic                                settled,
  output logic [kmds_pkg::PRESSED_W-1:0]      pressed_count
);

  localparam int CIW = (COLS > 1) ? $clog2(COLS) : 1;

  kmds_pkg::lane_status_t [ROWS-1:0] lane_st;
  logic                              fire;
  logic                              in_range;
  logic                              is_last;
  logic                              update;
  logic                              commit;
  logic [CIW-1:0]                    col_idx;

  // Decode the item's column.
  assign fire     = item_valid & ~item_stall;
  assign in_range = (32'(column) < 32'(COLS));
  assign is_last  = (32'(column) == 32'(COLS - 1));
  assign update   = fire & in_range;
  assign col_idx  = column[CIW-1:0];

  // One lane per row; sense bits beyond the field read as not pressed.
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    localparam int SI = ROWS - 1 - r;
    logic sense_bit;

    if (SI < kmds_pkg::SENSE_W) begin : g_bit
      assign sense_bit = row_sense[SI];
    end else begin : g_zero
      assign sense_bit = 1'b0;
    end

    kmds_lane #(
      .COLS(COLS)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .en       (update),
      .col_idx  (col_idx),
      .sense_bit(sense_bit),
      .commit   (commit),
      .status   (lane_st[r])
    );
  end

  // Counter, tallies and output register.
  kmds_merge #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_merge (
    .clk               (clk),
    .rst               (rst),
    .fire              (fire),
    .in_range          (in_range),
    .is_last           (is_last),
    .lane_st           (lane_st),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .result_stall      (result_stall),
    .commit            (commit),
    .item_stall        (item_stall),
    .result_valid      (result_valid),
    .stable_column_bits(stable_column_bits),
    .committed         (committed),
    .settled           (settled),
    .pressed_count     (pressed_count)
  );

endmodule

`default_nettype wire

### sv/kmds_checker.sv
`default_nettype none

module kmds_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            item_valid,
  input wire                            item_stall,
  input wire                            result_valid,
  input wire                            result_stall,
  input wire [kmds_pkg::STABLE_W-1:0]   stable_column_bits,
  input wire                            committed,
  input wire                            settled,
  input wire [kmds_pkg::PRESSED_W-1:0]  pressed_count
);

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result item present after reset");

  // Every accepted item shows up as a result in the next cycle.
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> result_valid)
    else $error("accepted item produced no result");

  // A commit always leaves the counter at zero.
  a_commit_settled: assert property (@(posedge clk) disable iff (rst)
    (result_valid && committed) |-> settled)
    else $error("commit reported without settled");

  // The pressed count only changes on a result that commits.
  a_count_moves_on_commit: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall) ##1 (result_valid && !committed)
      |-> pressed_count == $past(pressed_count))
    else $error("pressed count changed without a commit");

  // A stalled result holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=>
      (result_valid && $stable(stable_column_bits) && $stable(committed)
       && $stable(settled) && $stable(pressed_count)))
    else $error("stalled result changed");

endmodule

bind key_matrix_debounce_scanner kmds_checker u_kmds_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item_valid),
  .item_stall        (item_stall),
  .result_valid      (result_valid),
  .result_stall      (result_stall),
  .stable_column_bits(stable_column_bits),
  .committed         (committed),
  .settled           (settled),
  .pressed_count     (pressed_count)
);

`default_nettype wire
